// ===== rtl/core/imu_spc_pkg.sv =====
// Shared types and constants for the IMU stationary point capture core.
// Used by the controller, the datapath and the top level; no dependencies.
package imu_spc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 40;
  localparam int VEC_W       = 40;
  localparam int FILT_W      = 32;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = 16;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_ALPHA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_ALPHA  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_EN    = 3'd7;

  typedef enum logic [2:0] {
    FUNC_START, FUNC_STOP, FUNC_GYRO, FUNC_ACCEL, FUNC_MAGN
  } func_e;

  typedef enum logic [2:0] {
    KIND_STATUS, KIND_GSUM, KIND_GFILT, KIND_AFILT, KIND_MFILT
  } kind_e;

  typedef enum logic [1:0] {
    PH_STOPPED, PH_RESET, PH_MOVING, PH_STABLE
  } phase_e;

  // Filter bank selected for a mean/filter/deviation pass
  typedef enum logic [1:0] {
    FS_MEAN, FS_GYRO, FS_ACCEL, FS_MAGN
  } fsel_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_START, OP_STOP, OP_MUL, OP_UPD, OP_SQ, OP_ACC,
    OP_GACT, OP_LOAD, OP_BREAK, OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_MUL, ST_UPD, ST_SQ, ST_ACC, ST_CHECK,
    ST_BREAK, ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
    fsel_e      fsel;
    kind_e      kind;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    phase_e     phase;
    logic       sens_en;
    logic       sens_first;
    logic       exceeds;
    logic       still;
  } dp_stat_t;

endpackage

// ===== rtl/core/imu_spc_datapath.sv =====
// Datapath of the IMU stationary point capture core: config registers,
// capture state, axis-serial filter and deviation units, result register.
// Depends on imu_spc_pkg.
module imu_spc_datapath #(
  parameter int SAMPLE_BITS = imu_spc_pkg::SAMPLE_BITS,
  parameter int SUM_BITS    = imu_spc_pkg::SUM_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [imu_spc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [imu_spc_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [2:0]                            func_i,
  input  logic [imu_spc_pkg::TIME_W-1:0]        sample_time_i,
  input  logic signed [SAMPLE_BITS-1:0]         axis_x_i,
  input  logic signed [SAMPLE_BITS-1:0]         axis_y_i,
  input  logic signed [SAMPLE_BITS-1:0]         axis_z_i,
  input  logic [imu_spc_pkg::CNT_W-1:0]         point_limit_i,
  input  imu_spc_pkg::dp_cmd_t                  cmd_i,
  output imu_spc_pkg::dp_stat_t                 stat_o,
  output logic [2:0]                            kind_o,
  output logic signed [imu_spc_pkg::VEC_W-1:0]  vec_x_o,
  output logic signed [imu_spc_pkg::VEC_W-1:0]  vec_y_o,
  output logic signed [imu_spc_pkg::VEC_W-1:0]  vec_z_o,
  output logic [imu_spc_pkg::TIME_W-1:0]        move_start_o,
  output logic [imu_spc_pkg::TIME_W-1:0]        move_end_o,
  output logic [imu_spc_pkg::CNT_W-1:0]         points_done_o,
  output logic [1:0]                            phase_o,
  output logic                                  last_o
);

  localparam int SB   = SAMPLE_BITS;
  localparam int SW   = SUM_BITS;
  localparam int SW1  = SUM_BITS + 1;
  localparam int SBIG = SAMPLE_BITS + 16;
  localparam int DW   = ((SBIG > 32) ? SBIG : 32) + 1;
  localparam int PW   = DW + 17;
  localparam int PW1  = PW + 1;
  localparam int VW   = imu_spc_pkg::VEC_W;
  localparam int SVW  = SUM_BITS + imu_spc_pkg::VEC_W;
  localparam int FW   = imu_spc_pkg::FILT_W;
  localparam int TW   = imu_spc_pkg::TIME_W;
  localparam int CW   = imu_spc_pkg::CNT_W;

  // Sample in Q16.16, sign-extended to the difference width
  function automatic logic signed [DW-1:0] to_q16(input logic signed [SB-1:0] s);
    logic signed [SBIG-1:0] t;
    t = {s, 16'h0};
    return DW'(t);
  endfunction

  // Saturate a wide signed value to the filter width
  function automatic logic signed [FW-1:0] sat_filt(input logic signed [DW-1:0] v);
    if (v[DW-1:FW-1] == '0 || v[DW-1:FW-1] == '1) begin
      return v[FW-1:0];
    end else begin
      return v[DW-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    end
  endfunction

  // Saturating accumulate of one raw sample into the sum width
  function automatic logic signed [SW-1:0] sum_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SB-1:0] s);
    logic signed [SW:0] r;
    r = SW1'(a) + SW1'(s);
    if (r[SW] != r[SW-1]) begin
      return r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      return r[SW-1:0];
    end
  endfunction

  // Configuration registers
  logic [15:0]   gyro_alpha_q, gyro_lim_q, acc_alpha_q, acc_lim_q, mag_alpha_q, mag_lim_q;
  logic [TW-1:0] settle_q;
  logic [1:0]    sens_en_q;

  // Latched input item
  logic [2:0]              func_q;
  logic [TW-1:0]           time_q;
  logic signed [SB-1:0]    smp_q [3];
  logic [CW-1:0]           plim_q;

  // Capture state
  imu_spc_pkg::phase_e     phase_q;
  logic [CW-1:0]           done_q, limit_q;
  logic [TW-1:0]           stable_since_q, start_q, end_q;
  logic                    acc_first_q, mag_first_q;
  logic signed [SW-1:0]    sum_q   [3];
  logic signed [FW-1:0]    mean_q  [3];
  logic signed [FW-1:0]    gfilt_q [3];
  logic signed [FW-1:0]    afilt_q [3];
  logic signed [FW-1:0]    mfilt_q [3];

  // Axis-serial arithmetic
  logic signed [PW-1:0]    prod_q;
  logic [61:0]             sq_q;
  logic [63:0]             acc_q;

  // Result register
  logic [2:0]              kind_q;
  logic signed [VW-1:0]    vec_q [3];
  logic [TW-1:0]           ostart_q, oend_q;
  logic [CW-1:0]           odone_q;
  logic [1:0]              ophase_q;
  logic                    olast_q;

  // Selected filter, sample and weights for the current axis
  logic signed [FW-1:0]    f_sel;
  logic [15:0]             alpha_sel, lim_sel;
  logic signed [DW-1:0]    s_ext, f_ext, diff_w;
  logic [DW-1:0]           abs_w, shr_w;
  logic [30:0]             mag_w;
  logic signed [PW-1:0]    prod_d;
  logic signed [PW:0]      upd_w;
  logic signed [DW-1:0]    upd_sat_in;
  logic signed [FW-1:0]    f_new;
  logic [31:0]             lim_sq;
  logic                    exceeds_w, still_w;
  logic [CW-1:0]           done_inc;

  always_comb begin
    case (cmd_i.fsel)
      imu_spc_pkg::FS_MEAN:  f_sel = mean_q[cmd_i.axis];
      imu_spc_pkg::FS_GYRO:  f_sel = gfilt_q[cmd_i.axis];
      imu_spc_pkg::FS_ACCEL: f_sel = afilt_q[cmd_i.axis];
      default:               f_sel = mfilt_q[cmd_i.axis];
    endcase
    case (cmd_i.fsel)
      imu_spc_pkg::FS_ACCEL: begin alpha_sel = acc_alpha_q;  lim_sel = acc_lim_q;  end
      imu_spc_pkg::FS_MAGN:  begin alpha_sel = mag_alpha_q;  lim_sel = mag_lim_q;  end
      default:               begin alpha_sel = gyro_alpha_q; lim_sel = gyro_lim_q; end
    endcase
  end

  // Filter step: product of weight and error, then rounded update
  assign s_ext  = to_q16(smp_q[cmd_i.axis]);
  assign f_ext  = DW'(f_sel);
  assign prod_d = PW'(s_ext - f_ext) * PW'(signed'({1'b0, alpha_sel})) + PW'(32'sd32768);
  assign upd_w  = PW1'(f_sel) + PW1'(prod_q >>> 16);
  assign upd_sat_in = (upd_w[PW:DW-1] == '0 || upd_w[PW:DW-1] == '1) ? upd_w[DW-1:0] :
                      (upd_w[PW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});
  assign f_new  = sat_filt(upd_sat_in);

  // Deviation step: clipped magnitude of the error, squared
  assign diff_w = f_ext - s_ext;
  assign abs_w  = diff_w[DW-1] ? DW'(-diff_w) : DW'(diff_w);
  assign shr_w  = abs_w >> 8;
  assign mag_w  = (|shr_w[DW-1:31]) ? 31'h7FFF_FFFF : shr_w[30:0];

  assign lim_sq    = 32'(lim_sel) * 32'(lim_sel);
  assign exceeds_w = acc_q > {16'h0, lim_sq, 16'h0};
  assign still_w   = !exceeds_w && ((time_q - stable_since_q) > settle_q);
  assign done_inc  = (done_q == '1) ? done_q : done_q + 1'b1;

  // Status toward the controller
  always_comb begin
    stat_o.func       = func_q;
    stat_o.phase      = phase_q;
    stat_o.sens_en    = (func_q == imu_spc_pkg::FUNC_ACCEL) ? sens_en_q[0] : sens_en_q[1];
    stat_o.sens_first = (func_q == imu_spc_pkg::FUNC_ACCEL) ? acc_first_q : mag_first_q;
    stat_o.exceeds    = exceeds_w;
    stat_o.still      = still_w;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_alpha_q <= 16'd3277;
      gyro_lim_q   <= 16'd200;
      settle_q     <= 32'd1000;
      acc_alpha_q  <= 16'd3277;
      acc_lim_q    <= 16'd500;
      mag_alpha_q  <= 16'd3277;
      mag_lim_q    <= 16'd500;
      sens_en_q    <= 2'b11;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imu_spc_pkg::REG_GYRO_ALPHA: gyro_alpha_q <= cfg_wdata_i[15:0];
        imu_spc_pkg::REG_GYRO_LIMIT: gyro_lim_q   <= cfg_wdata_i[15:0];
        imu_spc_pkg::REG_SETTLE:     settle_q     <= cfg_wdata_i;
        imu_spc_pkg::REG_ACC_ALPHA:  acc_alpha_q  <= cfg_wdata_i[15:0];
        imu_spc_pkg::REG_ACC_LIMIT:  acc_lim_q    <= cfg_wdata_i[15:0];
        imu_spc_pkg::REG_MAG_ALPHA:  mag_alpha_q  <= cfg_wdata_i[15:0];
        imu_spc_pkg::REG_MAG_LIMIT:  mag_lim_q    <= cfg_wdata_i[15:0];
        default:                     sens_en_q    <= cfg_wdata_i[1:0];
      endcase
    end
  end

  // Latch the input beat and run the arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == imu_spc_pkg::OP_LATCH) begin
      func_q   <= func_i;
      time_q   <= sample_time_i;
      smp_q[0] <= axis_x_i;
      smp_q[1] <= axis_y_i;
      smp_q[2] <= axis_z_i;
      plim_q   <= point_limit_i;
    end
    if (cmd_i.op == imu_spc_pkg::OP_MUL) begin
      prod_q <= prod_d;
    end
    if (cmd_i.op == imu_spc_pkg::OP_SQ) begin
      sq_q <= 62'(mag_w) * 62'(mag_w);
    end
    if (cmd_i.op == imu_spc_pkg::OP_ACC) begin
      acc_q <= ((cmd_i.axis == 2'd0) ? 64'h0 : acc_q) + 64'(sq_q);
    end
  end

  // Capture state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= imu_spc_pkg::PH_STOPPED;
      done_q         <= '0;
      limit_q        <= '0;
      stable_since_q <= '0;
      start_q        <= '0;
      end_q          <= '0;
      acc_first_q    <= 1'b0;
      mag_first_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]   <= '0;
        mean_q[i]  <= '0;
        gfilt_q[i] <= '0;
        afilt_q[i] <= '0;
        mfilt_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        imu_spc_pkg::OP_START: begin
          limit_q     <= plim_q;
          done_q      <= '0;
          phase_q     <= imu_spc_pkg::PH_RESET;
          acc_first_q <= 1'b0;
          mag_first_q <= 1'b0;
        end
        imu_spc_pkg::OP_STOP: begin
          phase_q     <= imu_spc_pkg::PH_STOPPED;
          acc_first_q <= 1'b0;
          mag_first_q <= 1'b0;
        end
        imu_spc_pkg::OP_UPD: begin
          case (cmd_i.fsel)
            imu_spc_pkg::FS_MEAN:  mean_q[cmd_i.axis]  <= f_new;
            imu_spc_pkg::FS_GYRO:  gfilt_q[cmd_i.axis] <= f_new;
            imu_spc_pkg::FS_ACCEL: afilt_q[cmd_i.axis] <= f_new;
            default:               mfilt_q[cmd_i.axis] <= f_new;
          endcase
        end
        imu_spc_pkg::OP_GACT: begin
          if (exceeds_w) begin
            stable_since_q <= time_q;
          end
          case (phase_q)
            imu_spc_pkg::PH_RESET: begin
              for (int i = 0; i < 3; i++) sum_q[i] <= SW'(smp_q[i]);
              stable_since_q <= time_q;
              start_q        <= time_q;
              end_q          <= time_q;
              phase_q        <= imu_spc_pkg::PH_MOVING;
            end
            imu_spc_pkg::PH_MOVING: begin
              if (!still_w) begin
                for (int i = 0; i < 3; i++) sum_q[i] <= sum_add(sum_q[i], smp_q[i]);
                end_q <= time_q;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  gfilt_q[i] <= sat_filt(to_q16(smp_q[i]));
                  afilt_q[i] <= '0;
                  mfilt_q[i] <= '0;
                end
                acc_first_q <= 1'b1;
                mag_first_q <= 1'b1;
                phase_q     <= imu_spc_pkg::PH_STABLE;
              end
            end
            default: ;
          endcase
        end
        imu_spc_pkg::OP_LOAD: begin
          // First sample after entering stable loads the filter
          if (cmd_i.fsel == imu_spc_pkg::FS_ACCEL) begin
            for (int i = 0; i < 3; i++) afilt_q[i] <= sat_filt(to_q16(smp_q[i]));
            acc_first_q <= 1'b0;
          end else begin
            for (int i = 0; i < 3; i++) mfilt_q[i] <= sat_filt(to_q16(smp_q[i]));
            mag_first_q <= 1'b0;
          end
        end
        imu_spc_pkg::OP_BREAK: begin
          done_q  <= done_inc;
          phase_q <= (limit_q != '0 && done_inc >= limit_q) ? imu_spc_pkg::PH_STOPPED
                                                           : imu_spc_pkg::PH_RESET;
        end
        default: ;
      endcase
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == imu_spc_pkg::OP_EMIT) begin
      kind_q   <= cmd_i.kind;
      ostart_q <= start_q;
      oend_q   <= end_q;
      odone_q  <= done_q;
      ophase_q <= phase_q;
      olast_q  <= cmd_i.last;
      for (int i = 0; i < 3; i++) begin
        case (cmd_i.kind)
          imu_spc_pkg::KIND_GSUM:  vec_q[i] <= VW'(SVW'(sum_q[i]));
          imu_spc_pkg::KIND_GFILT: vec_q[i] <= VW'(gfilt_q[i]);
          imu_spc_pkg::KIND_AFILT: vec_q[i] <= VW'(afilt_q[i]);
          imu_spc_pkg::KIND_MFILT: vec_q[i] <= VW'(mfilt_q[i]);
          default:                 vec_q[i] <= '0;
        endcase
      end
    end
  end

  assign kind_o        = kind_q;
  assign vec_x_o       = vec_q[0];
  assign vec_y_o       = vec_q[1];
  assign vec_z_o       = vec_q[2];
  assign move_start_o  = ostart_q;
  assign move_end_o    = oend_q;
  assign points_done_o = odone_q;
  assign phase_o       = ophase_q;
  assign last_o        = olast_q;

endmodule

// ===== rtl/core/imu_spc_ctrl.sv =====
// Controller of the IMU stationary point capture core: sequences the
// datapath per item and drives both handshakes. Depends on imu_spc_pkg.
module imu_spc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  imu_spc_pkg::dp_stat_t  stat_i,
  output imu_spc_pkg::dp_cmd_t   cmd_o
);

  imu_spc_pkg::ctl_state_e state_q, state_d;
  logic [1:0]              ax_q, ax_d, k_q, k_d;
  imu_spc_pkg::fsel_e      fsel_q, fsel_d, sens_sel;
  logic                    brk_q, brk_d, out_valid_q, out_valid_d, out_free;

  assign sens_sel = (stat_i.func == imu_spc_pkg::FUNC_ACCEL) ? imu_spc_pkg::FS_ACCEL
                                                             : imu_spc_pkg::FS_MAGN;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imu_spc_pkg::ST_IDLE;
      ax_q        <= '0;
      k_q         <= '0;
      fsel_q      <= imu_spc_pkg::FS_MEAN;
      brk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      k_q         <= k_d;
      fsel_q      <= fsel_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    k_d         = k_q;
    fsel_d      = fsel_q;
    brk_d       = brk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = imu_spc_pkg::OP_NONE;
    cmd_o.axis  = ax_q;
    cmd_o.fsel  = fsel_q;
    cmd_o.kind  = imu_spc_pkg::KIND_STATUS;
    cmd_o.last  = 1'b1;
    case (state_q)
      imu_spc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = imu_spc_pkg::OP_LATCH;
          state_d  = imu_spc_pkg::ST_DISPATCH;
        end
      end
      imu_spc_pkg::ST_DISPATCH: begin
        brk_d   = 1'b0;
        k_d     = '0;
        ax_d    = '0;
        state_d = imu_spc_pkg::ST_EMIT;
        case (stat_i.func)
          imu_spc_pkg::FUNC_START: cmd_o.op = imu_spc_pkg::OP_START;
          imu_spc_pkg::FUNC_STOP:  cmd_o.op = imu_spc_pkg::OP_STOP;
          imu_spc_pkg::FUNC_GYRO: begin
            if (stat_i.phase != imu_spc_pkg::PH_STOPPED) begin
              fsel_d  = imu_spc_pkg::FS_MEAN;
              state_d = imu_spc_pkg::ST_MUL;
            end
          end
          imu_spc_pkg::FUNC_ACCEL, imu_spc_pkg::FUNC_MAGN: begin
            if (stat_i.phase == imu_spc_pkg::PH_STABLE && stat_i.sens_en) begin
              if (stat_i.sens_first) begin
                cmd_o.op   = imu_spc_pkg::OP_LOAD;
                cmd_o.fsel = sens_sel;
              end else begin
                fsel_d  = sens_sel;
                state_d = imu_spc_pkg::ST_SQ;
              end
            end
          end
          default: ;
        endcase
      end
      imu_spc_pkg::ST_MUL: begin
        cmd_o.op = imu_spc_pkg::OP_MUL;
        state_d  = imu_spc_pkg::ST_UPD;
      end
      imu_spc_pkg::ST_UPD: begin
        cmd_o.op = imu_spc_pkg::OP_UPD;
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          state_d = (fsel_q == imu_spc_pkg::FS_MEAN) ? imu_spc_pkg::ST_SQ
                                                     : imu_spc_pkg::ST_EMIT;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = imu_spc_pkg::ST_MUL;
        end
      end
      imu_spc_pkg::ST_SQ: begin
        cmd_o.op = imu_spc_pkg::OP_SQ;
        state_d  = imu_spc_pkg::ST_ACC;
      end
      imu_spc_pkg::ST_ACC: begin
        cmd_o.op = imu_spc_pkg::OP_ACC;
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          state_d = imu_spc_pkg::ST_CHECK;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = imu_spc_pkg::ST_SQ;
        end
      end
      imu_spc_pkg::ST_CHECK: begin
        if (stat_i.func == imu_spc_pkg::FUNC_GYRO) begin
          cmd_o.op = imu_spc_pkg::OP_GACT;
          if (stat_i.phase == imu_spc_pkg::PH_STABLE) begin
            if (stat_i.still) begin
              fsel_d  = imu_spc_pkg::FS_GYRO;
              state_d = imu_spc_pkg::ST_MUL;
            end else begin
              state_d = imu_spc_pkg::ST_BREAK;
            end
          end else begin
            state_d = imu_spc_pkg::ST_EMIT;
          end
        end else begin
          // Jump on a stable sensor breaks the point, else filter it
          state_d = stat_i.exceeds ? imu_spc_pkg::ST_BREAK : imu_spc_pkg::ST_MUL;
        end
      end
      imu_spc_pkg::ST_BREAK: begin
        cmd_o.op = imu_spc_pkg::OP_BREAK;
        brk_d    = 1'b1;
        state_d  = imu_spc_pkg::ST_EMIT;
      end
      imu_spc_pkg::ST_EMIT: begin
        if (brk_q) begin
          case (k_q)
            2'd0:    cmd_o.kind = imu_spc_pkg::KIND_GSUM;
            2'd1:    cmd_o.kind = imu_spc_pkg::KIND_GFILT;
            2'd2:    cmd_o.kind = imu_spc_pkg::KIND_AFILT;
            default: cmd_o.kind = imu_spc_pkg::KIND_MFILT;
          endcase
          cmd_o.last = (k_q == 2'd3);
        end
        if (out_free) begin
          cmd_o.op    = imu_spc_pkg::OP_EMIT;
          out_valid_d = 1'b1;
          if (brk_q && k_q != 2'd3) begin
            k_d = k_q + 2'd1;
          end else begin
            state_d = imu_spc_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = imu_spc_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/imu_stationary_point_capture_core.sv =====
// IMU stationary point capture: one item in flight at a time. Start, stop and
// ignored items go from dispatch straight to the result; a gyro item runs the
// mean filter pass and the deviation pass, and a further gyro filter pass while
// stable and still, on the axis-serial filter multiplier and squaring unit;
// accel and magn items load the filter or run the deviation and filter passes; a
// break emits four result beats, one per cycle while the output is not stalled.
module imu_stationary_point_capture_core #(
  parameter int SAMPLE_BITS = imu_spc_pkg::SAMPLE_BITS,
  parameter int SUM_BITS    = imu_spc_pkg::SUM_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [imu_spc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [imu_spc_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [2:0]                            func_i,
  input  logic [imu_spc_pkg::TIME_W-1:0]        sample_time_i,
  input  logic signed [SAMPLE_BITS-1:0]         axis_x_i,
  input  logic signed [SAMPLE_BITS-1:0]         axis_y_i,
  input  logic signed [SAMPLE_BITS-1:0]         axis_z_i,
  input  logic [imu_spc_pkg::CNT_W-1:0]         point_limit_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [2:0]                            kind_o,
  output logic signed [imu_spc_pkg::VEC_W-1:0]  vec_x_o,
  output logic signed [imu_spc_pkg::VEC_W-1:0]  vec_y_o,
  output logic signed [imu_spc_pkg::VEC_W-1:0]  vec_z_o,
  output logic [imu_spc_pkg::TIME_W-1:0]        move_start_o,
  output logic [imu_spc_pkg::TIME_W-1:0]        move_end_o,
  output logic [imu_spc_pkg::CNT_W-1:0]         points_done_o,
  output logic [1:0]                            phase_o,
  output logic                                  last_o
);

  imu_spc_pkg::dp_cmd_t  cmd;
  imu_spc_pkg::dp_stat_t stat;

  imu_spc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  imu_spc_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .sample_time_i (sample_time_i),
    .axis_x_i      (axis_x_i),
    .axis_y_i      (axis_y_i),
    .axis_z_i      (axis_z_i),
    .point_limit_i (point_limit_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_o        (kind_o),
    .vec_x_o       (vec_x_o),
    .vec_y_o       (vec_y_o),
    .vec_z_o       (vec_z_o),
    .move_start_o  (move_start_o),
    .move_end_o    (move_end_o),
    .points_done_o (points_done_o),
    .phase_o       (phase_o),
    .last_o        (last_o)
  );

  // One item at a time: no second accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // Status beats are single and carry no vector
  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == imu_spc_pkg::KIND_STATUS) |->
      (last_o && vec_x_o == '0 && vec_y_o == '0 && vec_z_o == '0))
    else $error("malformed status beat");

  // Only the magnetometer vector closes a point
  a_point_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != imu_spc_pkg::KIND_STATUS) |->
      (last_o == (kind_o == imu_spc_pkg::KIND_MFILT)))
    else $error("point beat with wrong last flag");

endmodule
